@@ rtl/i2cms_pkg.sv @@
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int FUNC_W    = 2;
    localparam int LEN_W     = 8;
    localparam int ADDR_W    = 7;
    localparam int FLAG_W    = 11;
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 3;
    localparam int VAL_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;

    localparam int MAX_LEN     = 255;
    localparam int NSLOT       = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_ERR     = 5;

    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_EVENT = 2'd2;
    localparam logic [FUNC_W-1:0] FN_ERROR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CONTROL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_IRQ   = 1'b1;

    // status flag bit positions
    localparam int F_SB   = 0;
    localparam int F_ADDR = 1;
    localparam int F_BTF  = 2;
    localparam int F_STOP = 3;
    localparam int F_TXE  = 4;
    localparam int F_RXNE = 5;
    localparam int F_BERR = 6;

    localparam logic [VAL_W-1:0] N_TX_DONE = 8'd0;
    localparam logic [VAL_W-1:0] N_RX_DONE = 8'd1;
    localparam logic [VAL_W-1:0] N_STOPF   = 8'd2;
    localparam logic [VAL_W-1:0] N_BERR    = 8'd3;
    localparam logic [VAL_W-1:0] N_SLV_REQ = 8'd8;
    localparam logic [VAL_W-1:0] N_SLV_RX  = 8'd9;

    localparam logic [VAL_W-1:0] ST_CODE_READY = 8'd0;
    localparam logic [VAL_W-1:0] ST_CODE_RX    = 8'd1;
    localparam logic [VAL_W-1:0] ST_CODE_TX    = 8'd2;

    typedef enum logic [ACT_W-1:0] {
        A_STATUS  = 3'd0,
        A_START   = 3'd1,
        A_WRITE   = 3'd2,
        A_CLRADDR = 3'd3,
        A_ACK     = 3'd4,
        A_STOP    = 3'd5,
        A_STORE   = 3'd6,
        A_NOTIFY  = 3'd7
    } action_e;

    typedef enum logic [2:0] {
        XS_READY = 3'b001,
        XS_RX    = 3'b010,
        XS_TX    = 3'b100
    } xfer_e;

    typedef struct packed {
        action_e          action;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic [NSLOT-1:0] valid;
        slot_t [NSLOT-1:0] slot;
    } batch_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic slot_t mk_slot(action_e a, logic [VAL_W-1:0] v);
        slot_t s;
        s.action = a;
        s.value  = v;
        return s;
    endfunction

    function automatic logic [VAL_W-1:0] status_code(xfer_e x);
        logic [VAL_W-1:0] c;
        case (x)
            XS_RX:   c = ST_CODE_RX;
            XS_TX:   c = ST_CODE_TX;
            default: c = ST_CODE_READY;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/i2cms_if.sv @@
`timescale 1ns / 1ps

interface i2cms_req_if;
    logic                             valid;
    logic                             ready;
    logic [i2cms_pkg::FUNC_W-1:0]     func;
    logic [i2cms_pkg::LEN_W-1:0]      length;
    logic [i2cms_pkg::ADDR_W-1:0]     slave_addr;
    logic                             repeated_start;
    logic [i2cms_pkg::FLAG_W-1:0]     status_flags;
    logic                             master_mode;
    logic                             transmitter;
    logic [i2cms_pkg::BYTE_W-1:0]     tx_byte;
    logic [i2cms_pkg::BYTE_W-1:0]     rx_byte;

    modport source (
        output valid, func, length, slave_addr, repeated_start, status_flags,
               master_mode, transmitter, tx_byte, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, func, length, slave_addr, repeated_start, status_flags,
               master_mode, transmitter, tx_byte, rx_byte,
        output ready
    );
endinterface

interface i2cms_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [i2cms_pkg::ACT_W-1:0]      action;
    logic [i2cms_pkg::VAL_W-1:0]      value;
    logic                             last;

    modport source (output valid, action, value, last, input ready);
    modport sink (input valid, action, value, last, output ready);
endinterface

interface i2cms_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [i2cms_pkg::CFG_IDX_W-1:0]  index;
    logic [i2cms_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/i2cms_front.sv @@
`timescale 1ns / 1ps

module i2cms_front (
    input  logic               clk,
    input  logic               rst_n,
    i2cms_req_if.sink          req,
    i2cms_cfg_if.sink          cfg,
    input  i2cms_pkg::q_stat_t qstat,
    output logic               push,
    output i2cms_pkg::batch_t  push_data
);
    import i2cms_pkg::*;

    xfer_e              xfer_reg, xfer_next, xfer_mid;
    logic [LEN_W-1:0]   tx_rem_reg, tx_rem_next;
    logic [LEN_W-1:0]   rx_rem_reg, rx_rem_next, rx_rem_dec;
    logic [LEN_W-1:0]   rx_total_reg, rx_total_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               hold_reg, hold_next;
    logic               ev_on_reg, ev_on_next;
    logic               buf_on_reg, buf_on_next;
    logic               err_on_reg, err_on_next;
    logic               ack_ctl_reg;
    logic               slv_irq_reg;

    logic               ev_en, buf_en, err_en;
    logic               btf_close;
    logic [LEN_W-1:0]   len_sat;
    logic               accept;
    batch_t             batch;

    assign req.ready = !qstat.full;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign push      = accept && (batch.valid != '0);
    assign push_data = batch;

    assign ev_en  = ev_on_reg || slv_irq_reg;
    assign buf_en = buf_on_reg || slv_irq_reg;
    assign err_en = err_on_reg || slv_irq_reg;

    always_comb
    begin
        xfer_next     = xfer_reg;
        tx_rem_next   = tx_rem_reg;
        rx_rem_next   = rx_rem_reg;
        rx_total_next = rx_total_reg;
        addr_next     = addr_reg;
        hold_next     = hold_reg;
        ev_on_next    = ev_on_reg;
        buf_on_next   = buf_on_reg;
        err_on_next   = err_on_reg;
        batch         = '0;
        xfer_mid      = xfer_reg;
        btf_close     = 1'b0;
        rx_rem_dec    = rx_rem_reg;
        if (32'(req.length) > MAX_LEN)
        begin
            len_sat = LEN_W'(MAX_LEN);
        end
        else
        begin
            len_sat = req.length;
        end

        case (req.func)
            FN_WRITE, FN_READ:
            begin
                batch.valid[0] = 1'b1;
                batch.slot[0]  = mk_slot(A_STATUS, status_code(xfer_reg));
                if (xfer_reg != XS_RX && xfer_reg != XS_TX)
                begin
                    if (req.func == FN_READ)
                    begin
                        rx_rem_next   = len_sat;
                        rx_total_next = len_sat;
                        xfer_next     = XS_RX;
                    end
                    else
                    begin
                        tx_rem_next = len_sat;
                        xfer_next   = XS_TX;
                    end
                    addr_next      = req.slave_addr;
                    hold_next      = req.repeated_start;
                    batch.valid[1] = 1'b1;
                    batch.slot[1]  = mk_slot(A_START, '0);
                    ev_on_next     = 1'b1;
                    buf_on_next    = 1'b1;
                    err_on_next    = 1'b1;
                end
            end
            FN_EVENT:
            begin
                // start bit sent: address byte with direction
                if (ev_en && req.status_flags[F_SB])
                begin
                    if (xfer_reg == XS_TX)
                    begin
                        batch.valid[0] = 1'b1;
                        batch.slot[0]  = mk_slot(A_WRITE, {addr_reg, 1'b0});
                    end
                    else if (xfer_reg == XS_RX)
                    begin
                        batch.valid[0] = 1'b1;
                        batch.slot[0]  = mk_slot(A_WRITE, {addr_reg, 1'b1});
                    end
                end
                if (ev_en && req.status_flags[F_ADDR])
                begin
                    if (req.master_mode && xfer_reg == XS_RX && rx_total_reg == LEN_W'(1))
                    begin
                        batch.valid[1] = 1'b1;
                        batch.slot[1]  = mk_slot(A_ACK, '0);
                    end
                    batch.valid[2] = 1'b1;
                    batch.slot[2]  = mk_slot(A_CLRADDR, '0);
                end
                // write finished
                btf_close = ev_en && req.status_flags[F_BTF] && xfer_reg == XS_TX
                            && req.status_flags[F_TXE] && tx_rem_reg == '0;
                if (btf_close)
                begin
                    batch.valid[3] = !hold_reg;
                    batch.slot[3]  = mk_slot(A_STOP, '0);
                    batch.valid[4] = 1'b1;
                    batch.slot[4]  = mk_slot(A_NOTIFY, N_TX_DONE);
                    ev_on_next     = 1'b0;
                    buf_on_next    = 1'b0;
                    xfer_next      = XS_READY;
                    xfer_mid       = XS_READY;
                    tx_rem_next    = '0;
                end
                if (ev_en && req.status_flags[F_STOP])
                begin
                    batch.valid[5] = 1'b1;
                    batch.slot[5]  = mk_slot(A_NOTIFY, N_STOPF);
                end
                if (ev_en && buf_en && req.status_flags[F_TXE])
                begin
                    if (req.master_mode)
                    begin
                        if (xfer_mid == XS_TX && tx_rem_reg != '0)
                        begin
                            batch.valid[6] = 1'b1;
                            batch.slot[6]  = mk_slot(A_WRITE, req.tx_byte);
                            tx_rem_next    = tx_rem_reg - LEN_W'(1);
                        end
                    end
                    else if (req.transmitter)
                    begin
                        batch.valid[6] = 1'b1;
                        batch.slot[6]  = mk_slot(A_NOTIFY, N_SLV_REQ);
                    end
                end
                if (ev_en && buf_en && req.status_flags[F_RXNE])
                begin
                    if (req.master_mode)
                    begin
                        if (xfer_mid == XS_RX)
                        begin
                            if (rx_total_reg > LEN_W'(1) && rx_rem_reg == LEN_W'(2))
                            begin
                                batch.valid[7] = 1'b1;
                                batch.slot[7]  = mk_slot(A_ACK, '0);
                            end
                            if (rx_total_reg != '0)
                            begin
                                batch.valid[8] = 1'b1;
                                batch.slot[8]  = mk_slot(A_STORE, req.rx_byte);
                                rx_rem_dec     = rx_rem_reg - LEN_W'(1);
                            end
                            rx_rem_next = rx_rem_dec;
                            if (rx_rem_dec == '0)
                            begin
                                batch.valid[9]  = !hold_reg;
                                batch.slot[9]   = mk_slot(A_STOP, '0);
                                batch.valid[10] = ack_ctl_reg;
                                batch.slot[10]  = mk_slot(A_ACK, VAL_W'(1));
                                batch.valid[11] = 1'b1;
                                batch.slot[11]  = mk_slot(A_NOTIFY, N_RX_DONE);
                                ev_on_next      = 1'b0;
                                buf_on_next     = 1'b0;
                                xfer_next       = XS_READY;
                                rx_rem_next     = '0;
                                rx_total_next   = '0;
                            end
                        end
                    end
                    else if (!req.transmitter)
                    begin
                        batch.valid[8] = 1'b1;
                        batch.slot[8]  = mk_slot(A_NOTIFY, N_SLV_RX);
                    end
                end
            end
            FN_ERROR:
            begin
                if (err_en)
                begin
                    for (int i = 0; i < NUM_ERR; i++)
                    begin
                        batch.valid[i] = req.status_flags[F_BERR + i];
                        batch.slot[i]  = mk_slot(A_NOTIFY, N_BERR + VAL_W'(i));
                    end
                end
            end
            default:
            begin
                batch = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xfer_reg     <= XS_READY;
            tx_rem_reg   <= '0;
            rx_rem_reg   <= '0;
            rx_total_reg <= '0;
            addr_reg     <= '0;
            hold_reg     <= 1'b0;
            ev_on_reg    <= 1'b0;
            buf_on_reg   <= 1'b0;
            err_on_reg   <= 1'b0;
            ack_ctl_reg  <= 1'b1;
            slv_irq_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                xfer_reg     <= xfer_next;
                tx_rem_reg   <= tx_rem_next;
                rx_rem_reg   <= rx_rem_next;
                rx_total_reg <= rx_total_next;
                addr_reg     <= addr_next;
                hold_reg     <= hold_next;
                ev_on_reg    <= ev_on_next;
                buf_on_reg   <= buf_on_next;
                err_on_reg   <= err_on_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_ACK_CONTROL: ack_ctl_reg <= cfg.data[0];
                    CFG_SLAVE_IRQ:   slv_irq_reg <= cfg.data[0];
                    default:         ack_ctl_reg <= ack_ctl_reg;
                endcase
            end
        end
    end

endmodule

@@ rtl/i2cms_queue.sv @@
`timescale 1ns / 1ps

module i2cms_queue #(
    parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  i2cms_pkg::batch_t  push_data,
    input  logic               pop,
    output i2cms_pkg::batch_t  head,
    output i2cms_pkg::q_stat_t stat
);
    import i2cms_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    batch_t          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        logic [AW-1:0] n;
        if (p == AW'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + AW'(1);
        end
        return n;
    endfunction

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/i2cms_back.sv @@
`timescale 1ns / 1ps

module i2cms_back (
    input  logic               clk,
    input  logic               rst_n,
    input  i2cms_pkg::batch_t  head,
    input  i2cms_pkg::q_stat_t qstat,
    output logic               pop,
    i2cms_rsp_if.source        rsp
);
    import i2cms_pkg::*;

    logic [NSLOT-1:0]  sent_reg, sent_next;
    logic [NSLOT-1:0]  remaining, first_oh;
    slot_t             pick;
    logic              is_last;
    logic              load, emit;
    logic              valid_reg;
    action_e           action_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              last_reg;

    // lowest pending slot of the head request
    assign remaining = head.valid & ~sent_reg;
    assign first_oh  = remaining & (~remaining + NSLOT'(1));
    assign is_last   = ((remaining & ~first_oh) == '0);

    always_comb
    begin
        pick = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (first_oh[i])
            begin
                pick = head.slot[i];
            end
        end
    end

    assign load = !valid_reg || rsp.ready;
    assign emit = load && !qstat.empty;
    assign pop  = emit && is_last;

    always_comb
    begin
        if (pop)
        begin
            sent_next = '0;
        end
        else if (emit)
        begin
            sent_next = sent_reg | first_oh;
        end
        else
        begin
            sent_next = sent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= sent_next;
            if (load)
            begin
                valid_reg <= !qstat.empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            action_reg <= pick.action;
            value_reg  <= pick.value;
            last_reg   <= is_last;
        end
    end

    assign rsp.valid  = valid_reg;
    assign rsp.action = action_reg;
    assign rsp.value  = value_reg;
    assign rsp.last   = last_reg;

endmodule

@@ rtl/i2c_master_irq_transfer_sequencer.sv @@
// channel  | dir | handshake     | contents
// req      | in  | valid / ready | func, length, slave_addr, repeated_start, flags, bytes
// rsp      | out | valid / ready | action, value, last
// cfg      | in  | valid / ready | index, data (ready always high)
//
// a request yields 0 to 12 results, one per cycle while rsp.ready is high
// the first result passes through the request queue and then the output register
// req.ready drops only while the request queue (QUEUE_DEPTH entries) is full
// rsp.ready low holds the current result; requests keep entering until the queue fills
// reset clears the transfer state; ack_control resets to 1, slave_irq_enable to 0
`timescale 1ns / 1ps

module i2c_master_irq_transfer_sequencer #(
    parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cms_req_if.sink   req,
    i2cms_rsp_if.source rsp,
    i2cms_cfg_if.sink   cfg
);
    import i2cms_pkg::*;

    q_stat_t qstat;
    logic    push;
    logic    pop;
    batch_t  push_data;
    batch_t  head;

    i2cms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    i2cms_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

@@ rtl/i2cms_checker.sv @@
`timescale 1ns / 1ps

module i2cms_checker (
    input  logic        clk,
    input  logic        rst_n,
    i2cms_rsp_if.source rsp
);
    import i2cms_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.action)
            && $stable(rsp.value) && $stable(rsp.last))
        else $error("result changed while stalled");

    a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.action == A_START |-> rsp.last)
        else $error("start is not the final result of its request");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.action == A_START || rsp.action == A_STOP
            || rsp.action == A_CLRADDR) |-> rsp.value == '0)
        else $error("nonzero value on start, stop or address clear");

    a_ack_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.action == A_ACK |-> rsp.value[VAL_W-1:1] == '0)
        else $error("acknowledge level out of range");

    a_notice_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.action == A_NOTIFY |-> rsp.value <= N_SLV_RX)
        else $error("notice code out of range");

endmodule

bind i2c_master_irq_transfer_sequencer i2cms_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .rsp   (rsp)
);
